// ===== rtl/can_network_management_fsm_assert.svh =====
// Assertion macros for the CAN NM state machine checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef CAN_NETWORK_MANAGEMENT_FSM_ASSERT_SVH
`define CAN_NETWORK_MANAGEMENT_FSM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CNM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define CNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/cnm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CAN network-management state machine.
// No dependencies.
package cnm_pkg;

  localparam int CHANNELS_DEF = 4;

  // main state codes
  localparam logic [2:0] ST_SLEEP   = 3'd0;
  localparam logic [2:0] ST_REPEAT  = 3'd1;
  localparam logic [2:0] ST_NORMAL  = 3'd2;
  localparam logic [2:0] ST_READY   = 3'd3;
  localparam logic [2:0] ST_PREPARE = 3'd4;

  // state code carried in the NM frame
  localparam logic [2:0] TX_NONE         = 3'd0;
  localparam logic [2:0] TX_REP_FROM_BSM = 3'd1;
  localparam logic [2:0] TX_NRM_FROM_REP = 3'd2;
  localparam logic [2:0] TX_NRM_FROM_RSL = 3'd3;
  localparam logic [2:0] TX_REP_FROM_PBS = 3'd4;

  // config register indexes
  localparam logic [2:0] REG_REPEAT_MSG    = 3'd0;
  localparam logic [2:0] REG_IMMED_COUNT   = 3'd1;
  localparam logic [2:0] REG_IMMED_CYCLE   = 3'd2;
  localparam logic [2:0] REG_NM_CYCLE      = 3'd3;
  localparam logic [2:0] REG_NM_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_WAIT_BUS_SLP  = 3'd5;

  localparam logic [15:0] RST_REPEAT_MSG   = 16'd150;
  localparam logic [7:0]  RST_IMMED_COUNT  = 8'd3;
  localparam logic [15:0] RST_IMMED_CYCLE  = 16'd2;
  localparam logic [15:0] RST_NM_CYCLE     = 16'd50;
  localparam logic [15:0] RST_NM_TIMEOUT   = 16'd200;
  localparam logic [15:0] RST_WAIT_BUS_SLP = 16'd150;

  typedef struct packed {
    logic [15:0] repeat_msg_ticks;
    logic [7:0]  immediate_count;
    logic [15:0] immediate_cycle_ticks;
    logic [15:0] nm_cycle_ticks;
    logic [15:0] nm_timeout_ticks;
    logic [15:0] wait_bus_sleep_ticks;
  } cfg_t;

  // per-channel context word held in the state memory
  typedef struct packed {
    logic [2:0]  main_state;
    logic [15:0] phase_delay;
    logic [7:0]  burst_left;
    logic [15:0] interval_count;
    logic [15:0] timeout_count;
    logic        rx_pending;
    logic [2:0]  frame_state_code;
    logic        frame_wake_bit;
  } ctx_t;

  localparam ctx_t CTX_RST = '{
    main_state:       ST_SLEEP,
    phase_delay:      16'd0,
    burst_left:       8'd0,
    interval_count:   16'd0,
    timeout_count:    RST_NM_TIMEOUT,
    rx_pending:       1'b0,
    frame_state_code: TX_NONE,
    frame_wake_bit:   1'b0
  };

  typedef struct packed {
    logic [2:0] new_state;
    logic       send_nm;
    logic       app_open;
    logic       app_close;
    logic [2:0] tx_state_code;
    logic       wake_kind;
  } res_t;

endpackage

// ===== rtl/cnm_step.sv =====
`timescale 1ns / 1ps
// One tick of the NM state machine on one channel context: next context and result.
// Depends on cnm_pkg.
module cnm_step (
  input  cnm_pkg::ctx_t cur_i,
  input  logic          req_i,
  input  logic          rx_i,
  input  cnm_pkg::cfg_t cfg_i,
  output cnm_pkg::ctx_t nxt_o,
  output cnm_pkg::res_t res_o
);

  logic [2:0]  st;
  logic [2:0]  nx;
  logic        send;
  logic        open;
  logic        close;
  logic [2:0]  code;
  logic [15:0] to_dec;
  logic [15:0] to_run;
  logic [7:0]  burst_dec;
  cnm_pkg::ctx_t n;

  // timeout countdown as run while in repeat or normal
  always_comb begin
    to_dec = (cur_i.timeout_count != 16'd0) ? cur_i.timeout_count - 16'd1 : 16'd0;
    to_run = (to_dec == 16'd0) ? cfg_i.nm_timeout_ticks : to_dec;
  end

  assign burst_dec = cur_i.burst_left - 8'd1;

  always_comb begin
    n            = cur_i;
    n.rx_pending = cur_i.rx_pending | rx_i;
    st    = (cur_i.main_state > cnm_pkg::ST_PREPARE) ? cnm_pkg::ST_SLEEP : cur_i.main_state;
    nx    = st;
    send  = 1'b0;
    open  = 1'b0;
    close = 1'b0;
    code  = cnm_pkg::TX_NONE;

    unique case (st)
      cnm_pkg::ST_SLEEP: begin
        if (req_i) begin
          n.frame_wake_bit = 1'b1;
          code = cnm_pkg::TX_REP_FROM_BSM;
          nx   = cnm_pkg::ST_REPEAT;
        end else if (n.rx_pending) begin
          n.rx_pending     = 1'b0;
          n.frame_wake_bit = 1'b0;
          code = cnm_pkg::TX_REP_FROM_BSM;
          nx   = cnm_pkg::ST_REPEAT;
        end else begin
          close = 1'b1;
        end
      end
      cnm_pkg::ST_REPEAT: begin
        if (cur_i.phase_delay == 16'd0) begin
          if (req_i) begin
            code = cnm_pkg::TX_NRM_FROM_REP;
            nx   = cnm_pkg::ST_NORMAL;
          end else begin
            nx = cnm_pkg::ST_READY;
          end
        end else begin
          n.phase_delay = cur_i.phase_delay - 16'd1;
          if (cur_i.interval_count != 16'd0) begin
            n.interval_count = cur_i.interval_count - 16'd1;
          end else if (cur_i.burst_left != 8'd0) begin
            send         = 1'b1;
            n.burst_left = burst_dec;
            n.interval_count = (burst_dec == 8'd0) ? cfg_i.nm_cycle_ticks
                                                   : cfg_i.immediate_cycle_ticks;
          end else begin
            send             = 1'b1;
            n.interval_count = cfg_i.nm_cycle_ticks;
          end
          n.timeout_count = to_run;
        end
      end
      cnm_pkg::ST_NORMAL: begin
        n.rx_pending = 1'b0;
        if (!req_i) begin
          nx = cnm_pkg::ST_READY;
        end else begin
          if (cur_i.interval_count != 16'd0) begin
            n.interval_count = cur_i.interval_count - 16'd1;
          end else begin
            n.interval_count = cfg_i.nm_cycle_ticks;
            send = 1'b1;
          end
          n.timeout_count = to_run;
        end
      end
      cnm_pkg::ST_READY: begin
        if (req_i) begin
          n.interval_count = cfg_i.nm_cycle_ticks;
          send = 1'b1;
          code = cnm_pkg::TX_NRM_FROM_RSL;
          nx   = cnm_pkg::ST_NORMAL;
        end else if (n.rx_pending) begin
          n.rx_pending = 1'b0;
        end else if (cur_i.timeout_count != 16'd0) begin
          n.timeout_count = cur_i.timeout_count - 16'd1;
        end else begin
          nx = cnm_pkg::ST_PREPARE;
        end
      end
      default: begin
        if (req_i) begin
          code = cnm_pkg::TX_REP_FROM_PBS;
          nx   = cnm_pkg::ST_REPEAT;
        end else if (n.rx_pending) begin
          n.rx_pending = 1'b0;
          code = cnm_pkg::TX_REP_FROM_PBS;
          nx   = cnm_pkg::ST_REPEAT;
        end else if (cur_i.phase_delay != 16'd0) begin
          n.phase_delay = cur_i.phase_delay - 16'd1;
        end else begin
          nx = cnm_pkg::ST_SLEEP;
        end
      end
    endcase

    if (code != cnm_pkg::TX_NONE) begin
      n.frame_state_code = code;
    end

    // entry actions
    if (nx != st) begin
      if (nx == cnm_pkg::ST_REPEAT) begin
        n.phase_delay    = cfg_i.repeat_msg_ticks;
        n.burst_left     = cfg_i.immediate_count - 8'd1;
        n.interval_count = cfg_i.immediate_cycle_ticks;
        send = 1'b1;
        open = 1'b1;
      end else if (nx == cnm_pkg::ST_PREPARE) begin
        n.phase_delay = cfg_i.wait_bus_sleep_ticks;
        close = 1'b1;
      end
    end
    n.main_state = nx;
  end

  assign nxt_o = n;
  assign res_o = '{
    new_state:     nx,
    send_nm:       send,
    app_open:      open,
    app_close:     close,
    tx_state_code: code,
    wake_kind:     n.frame_wake_bit
  };

endmodule

// ===== rtl/can_network_management_fsm.sv =====
`timescale 1ns / 1ps
// CAN network-management state machine, one context per channel.
// Depends on cnm_pkg and cnm_step.
//
// Usage:
// - Input channel: one tick word per handshake (channel, request, nm_rx), taken
//   when in_valid_i is high and in_stall_o is low. Each tick advances the
//   addressed channel's state machine by one step.
// - Output channel: one result word per tick, handed over when out_valid_o is
//   high and out_stall_i is low. Ticks for a channel at or above CHANNELS are
//   dropped and give no result.
// - Stage 1 registers the tick and reads its context on the accepting edge; the
//   result enters the output register as stage 1 advances. Throughput: one tick
//   per cycle while the output is not held, set by the read-modify-write of the
//   context memory; back-to-back ticks on a channel bypass the last written context.
// - Stall: while the output word is held, the compute stage holds its tick and
//   in_stall_o rises only when that stage is full behind a held output.
// - Reset: all channels read as bus sleep with reset counters (context valid bits
//   cleared at once, no clearing pass); config registers take their reset values.
//   The user must make config writes only while the block is idle; not enforced.
module can_network_management_fsm #(
  parameter int CHANNELS = cnm_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  channel_i,
  input  logic        request_i,
  input  logic        nm_rx_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_channel_o,
  output logic [2:0]  new_state_o,
  output logic        send_nm_o,
  output logic        app_open_o,
  output logic        app_close_o,
  output logic [2:0]  tx_state_code_o,
  output logic        wake_kind_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------------------------------------------------------- config
  cnm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_msg_ticks      <= cnm_pkg::RST_REPEAT_MSG;
      cfg_q.immediate_count       <= cnm_pkg::RST_IMMED_COUNT;
      cfg_q.immediate_cycle_ticks <= cnm_pkg::RST_IMMED_CYCLE;
      cfg_q.nm_cycle_ticks        <= cnm_pkg::RST_NM_CYCLE;
      cfg_q.nm_timeout_ticks      <= cnm_pkg::RST_NM_TIMEOUT;
      cfg_q.wait_bus_sleep_ticks  <= cnm_pkg::RST_WAIT_BUS_SLP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cnm_pkg::REG_REPEAT_MSG:   cfg_q.repeat_msg_ticks      <= cfg_data_i;
        cnm_pkg::REG_IMMED_COUNT:  cfg_q.immediate_count       <= cfg_data_i[7:0];
        cnm_pkg::REG_IMMED_CYCLE:  cfg_q.immediate_cycle_ticks <= cfg_data_i;
        cnm_pkg::REG_NM_CYCLE:     cfg_q.nm_cycle_ticks        <= cfg_data_i;
        cnm_pkg::REG_NM_TIMEOUT:   cfg_q.nm_timeout_ticks      <= cfg_data_i;
        cnm_pkg::REG_WAIT_BUS_SLP: cfg_q.wait_bus_sleep_ticks  <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic out_vld_q;
  logic s1_vld_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = s1_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = s1_vld_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------- stage 1 regs
  logic [1:0] s1_ch_q;
  logic       s1_req_q;
  logic       s1_rx_q;
  logic       s1_present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q  <= channel_i;
      s1_req_q <= request_i;
      s1_rx_q  <= nm_rx_i;
    end
  end

  assign s1_present = (32'(s1_ch_q) < CHANNELS);

  // ---------------------------------------------------------------- context memory
  cnm_pkg::ctx_t         ctx_mem [CHANNELS];
  cnm_pkg::ctx_t         rd_q;
  logic                  rd_vld_q;
  logic [CHANNELS-1:0]   ctx_vld_q;
  logic [CH_W-1:0]       rd_addr;
  logic [CH_W-1:0]       wr_addr;
  logic                  wr_en;
  cnm_pkg::ctx_t         ctx_nxt;

  assign rd_addr = CH_W'(channel_i);
  assign wr_addr = CH_W'(s1_ch_q);
  assign wr_en   = s1_adv & s1_present;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ctx_mem[wr_addr] <= ctx_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q     <= ctx_mem[rd_addr];
      rd_vld_q <= ctx_vld_q[rd_addr];
    end
  end

  // entry valid bits: an unwritten context reads as the reset context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_vld_q <= '0;
    end else if (wr_en) begin
      ctx_vld_q[wr_addr] <= 1'b1;
    end
  end

  // bypass of the last write: covers a read taken on the same edge as the write
  cnm_pkg::ctx_t wb_q;
  logic [1:0]    wb_ch_q;
  logic          wb_vld_q;
  cnm_pkg::ctx_t ctx_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (wr_en) begin
      wb_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wb_q    <= ctx_nxt;
      wb_ch_q <= s1_ch_q;
    end
  end

  always_comb begin
    if (wb_vld_q && (wb_ch_q == s1_ch_q)) begin
      ctx_cur = wb_q;
    end else if (rd_vld_q) begin
      ctx_cur = rd_q;
    end else begin
      ctx_cur = cnm_pkg::CTX_RST;
    end
  end

  // ---------------------------------------------------------------- step logic
  cnm_pkg::res_t res;

  cnm_step u_step (
    .cur_i (ctx_cur),
    .req_i (s1_req_q),
    .rx_i  (s1_rx_q),
    .cfg_i (cfg_q),
    .nxt_o (ctx_nxt),
    .res_o (res)
  );

  // ---------------------------------------------------------------- output register
  logic [1:0]    out_ch_q;
  cnm_pkg::res_t out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_present;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_present) begin
      out_ch_q  <= s1_ch_q;
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_channel_o   = out_ch_q;
  assign new_state_o     = out_res_q.new_state;
  assign send_nm_o       = out_res_q.send_nm;
  assign app_open_o      = out_res_q.app_open;
  assign app_close_o     = out_res_q.app_close;
  assign tx_state_code_o = out_res_q.tx_state_code;
  assign wake_kind_o     = out_res_q.wake_kind;

endmodule

// ===== rtl/cnm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the CAN NM state machine, bound to the top level.
// Depends on cnm_pkg and can_network_management_fsm_assert.svh.
`include "can_network_management_fsm_assert.svh"

module cnm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_channel_o,
  input logic [2:0] new_state_o,
  input logic       send_nm_o,
  input logic       app_open_o,
  input logic [2:0] tx_state_code_o
);

  // held result word stays put
  `CNM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_channel_o) && $stable(new_state_o))

  // input backpressure only comes from a held output word
  `CNM_ASSERT_NOW(a_stall_src, in_stall_o, out_valid_o && out_stall_i)

  // entering repeat message always opens and sends
  `CNM_ASSERT_NOW(a_open_repeat, out_valid_o && app_open_o, new_state_o == cnm_pkg::ST_REPEAT && send_nm_o)

  // frame state code agrees with the target state
  `CNM_ASSERT_NOW(a_code_state, out_valid_o && (tx_state_code_o == cnm_pkg::TX_REP_FROM_BSM || tx_state_code_o == cnm_pkg::TX_REP_FROM_PBS), new_state_o == cnm_pkg::ST_REPEAT)

endmodule

bind can_network_management_fsm cnm_checker u_cnm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_channel_o   (out_channel_o),
  .new_state_o     (new_state_o),
  .send_nm_o       (send_nm_o),
  .app_open_o      (app_open_o),
  .tx_state_code_o (tx_state_code_o)
);

// ===== tb/can_network_management_fsm_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the per-channel CAN NM state machine.
// Depends on cnm_pkg and can_network_management_fsm; predicts each result word
// in a behavioral model of its own and compares it with the block's output.
module can_network_management_fsm_tb;
  import cnm_pkg::*;

  localparam int CHANNELS      = 4;
  localparam int WATCHDOG_MAX  = 4000;  // cycles with no handshake at all
  localparam int PRESSURE_HOLD = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 6;     // margin for the pipe to settle

  // indexes past the register map; writes there must have no effect
  localparam logic [2:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_7 = 3'd7;

  // one expected result word: channel plus the result fields
  typedef struct packed {
    logic [1:0] channel;
    res_t       res;
  } nm_expect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_REPEAT_MSG;
  logic [15:0] cfg_data_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  channel_i = 2'd0;
  logic        request_i = 1'b0;
  logic        nm_rx_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_channel_o;
  logic [2:0]  new_state_o;
  logic        send_nm_o;
  logic        app_open_o;
  logic        app_close_o;
  logic [2:0]  tx_state_code_o;
  logic        wake_kind_o;

  can_network_management_fsm #(.CHANNELS(CHANNELS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .channel_i       (channel_i),
    .request_i       (request_i),
    .nm_rx_i         (nm_rx_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_channel_o   (out_channel_o),
    .new_state_o     (new_state_o),
    .send_nm_o       (send_nm_o),
    .app_open_o      (app_open_o),
    .app_close_o     (app_close_o),
    .tx_state_code_o (tx_state_code_o),
    .wake_kind_o     (wake_kind_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the config registers and of every channel's context. Config
  // shadow follows each write; contexts follow each accepted tick word.
  // ---------------------------------------------------------------------------
  cfg_t       nm_cfg;
  ctx_t       chan_ctx [CHANNELS];
  nm_expect_t pending_results_q [$];
  logic       req_level [CHANNELS];   // per-channel request level for random runs

  int unsigned mismatch_count = 0;
  int unsigned gap_pct = 0;           // sender idle chance per cycle
  int unsigned stall_pct = 0;         // receiver stall chance per cycle
  logic        hold_req = 1'b0;       // toggle to start a long hold-off
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // NM timeout runs down and reloads from the register when it hits zero
  function automatic logic [15:0] run_nm_timeout(input logic [15:0] count);
    logic [15:0] next_count;
    next_count = (count != 16'd0) ? count - 16'd1 : count;
    if (next_count == 16'd0) next_count = nm_cfg.nm_timeout_ticks;
    return next_count;
  endfunction

  // One tick for one channel: latch reception, run the state's during action,
  // then the entry action of a new state. Returns the result word.
  function automatic nm_expect_t advance_channel(input logic [1:0] ch, input logic req,
                                                 input logic rx);
    ctx_t       c;
    logic [2:0] cur;
    logic [2:0] nxt;
    logic [2:0] code;
    logic       snd;
    logic       opn;
    logic       cls;
    nm_expect_t r;
    c    = chan_ctx[ch];
    code = TX_NONE;
    snd  = 1'b0;
    opn  = 1'b0;
    cls  = 1'b0;
    if (rx) c.rx_pending = 1'b1;
    // anything above prepare bus sleep counts as bus sleep
    cur = (c.main_state > ST_PREPARE) ? ST_SLEEP : c.main_state;
    nxt = cur;
    case (cur)
      ST_REPEAT: begin
        if (c.phase_delay == 16'd0) begin
          // dwell over: normal if still requested, else ready sleep
          if (req) begin
            code = TX_NRM_FROM_REP;
            nxt  = ST_NORMAL;
          end else begin
            nxt = ST_READY;
          end
        end else begin
          c.phase_delay = c.phase_delay - 16'd1;
          if (c.interval_count != 16'd0) begin
            c.interval_count = c.interval_count - 16'd1;
          end else if (c.burst_left != 8'd0) begin
            snd = 1'b1;
            c.burst_left = c.burst_left - 8'd1;
            c.interval_count = (c.burst_left == 8'd0) ? nm_cfg.nm_cycle_ticks
                                                      : nm_cfg.immediate_cycle_ticks;
          end else begin
            snd = 1'b1;
            c.interval_count = nm_cfg.nm_cycle_ticks;
          end
          c.timeout_count = run_nm_timeout(c.timeout_count);
        end
      end
      ST_NORMAL: begin
        c.rx_pending = 1'b0;
        if (!req) begin
          nxt = ST_READY;
        end else begin
          if (c.interval_count != 16'd0) begin
            c.interval_count = c.interval_count - 16'd1;
          end else begin
            c.interval_count = nm_cfg.nm_cycle_ticks;
            snd = 1'b1;
          end
          c.timeout_count = run_nm_timeout(c.timeout_count);
        end
      end
      ST_READY: begin
        if (req) begin
          c.interval_count = nm_cfg.nm_cycle_ticks;
          snd  = 1'b1;
          code = TX_NRM_FROM_RSL;
          nxt  = ST_NORMAL;
        end else if (c.rx_pending) begin
          c.rx_pending = 1'b0;
        end else if (c.timeout_count != 16'd0) begin
          c.timeout_count = c.timeout_count - 16'd1;
        end else begin
          nxt = ST_PREPARE;
        end
      end
      ST_PREPARE: begin
        if (req) begin
          code = TX_REP_FROM_PBS;
          nxt  = ST_REPEAT;
        end else if (c.rx_pending) begin
          c.rx_pending = 1'b0;
          code = TX_REP_FROM_PBS;
          nxt  = ST_REPEAT;
        end else if (c.phase_delay != 16'd0) begin
          c.phase_delay = c.phase_delay - 16'd1;
        end else begin
          nxt = ST_SLEEP;
        end
      end
      default: begin
        // bus sleep: local wake on request, passive wake on reception
        if (req) begin
          c.frame_wake_bit = 1'b1;
          code = TX_REP_FROM_BSM;
          nxt  = ST_REPEAT;
        end else if (c.rx_pending) begin
          c.rx_pending = 1'b0;
          c.frame_wake_bit = 1'b0;
          code = TX_REP_FROM_BSM;
          nxt  = ST_REPEAT;
        end else begin
          cls = 1'b1;
        end
      end
    endcase

    if (code != TX_NONE) c.frame_state_code = code;

    if (nxt != cur) begin
      if (nxt == ST_REPEAT) begin
        c.phase_delay    = nm_cfg.repeat_msg_ticks;
        c.burst_left     = nm_cfg.immediate_count - 8'd1;  // zero count wraps
        c.interval_count = nm_cfg.immediate_cycle_ticks;
        snd = 1'b1;
        opn = 1'b1;
      end else if (nxt == ST_PREPARE) begin
        c.phase_delay = nm_cfg.wait_bus_sleep_ticks;
        cls = 1'b1;
      end
    end
    c.main_state  = nxt;
    chan_ctx[ch]  = c;

    r.channel           = ch;
    r.res.new_state     = nxt;
    r.res.send_nm       = snd;
    r.res.app_open      = opn;
    r.res.app_close     = cls;
    r.res.tx_state_code = code;
    r.res.wake_kind     = c.frame_wake_bit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge, handshakes are seen on the rising.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_REPEAT_MSG:   nm_cfg.repeat_msg_ticks      = data;
      REG_IMMED_COUNT:  nm_cfg.immediate_count       = data[7:0];
      REG_IMMED_CYCLE:  nm_cfg.immediate_cycle_ticks = data;
      REG_NM_CYCLE:     nm_cfg.nm_cycle_ticks        = data;
      REG_NM_TIMEOUT:   nm_cfg.nm_timeout_ticks      = data;
      REG_WAIT_BUS_SLP: nm_cfg.wait_bus_sleep_ticks  = data;
      default: ;  // unmapped index, ignored
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick word; valid stays up after acceptance so words can go
  // back to back, and drops only on a random gap or at the end of a phase.
  task automatic send_tick(input logic [1:0] ch, input logic req, input logic rx);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    request_i  <= req;
    nm_rx_i    <= rx;
    do @(posedge clk_i); while (in_stall_o);
    pending_results_q.push_back(advance_channel(ch, req, rx));
  endtask

  // Channel 0 gets half the traffic so its timeout runs out and it reaches
  // prepare bus sleep and back; request levels flip now and then, and one
  // word in ten is plain noise.
  task automatic random_tick();
    logic [1:0] ch;
    logic       req;
    logic       rx;
    ch = ($urandom_range(99) < 50) ? 2'd0 : 2'($urandom_range(1, 3));
    if ($urandom_range(11) == 0) req_level[ch] = ~req_level[ch];
    req = req_level[ch];
    rx  = ($urandom_range(7) == 0);
    if ($urandom_range(9) == 0) begin
      req = 1'($urandom_range(1));
      rx  = 1'($urandom_range(1));
    end
    send_tick(ch, req, rx);
  endtask

  // Stop offering and wait for every expected word, then let the pipe settle.
  task automatic idle_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_random_config();
    write_reg(REG_REPEAT_MSG, 16'($urandom_range(0, 12)));
    write_reg(REG_IMMED_COUNT, ($urandom_range(7) == 0) ? 16'h0000
                                                        : 16'($urandom_range(1, 5)));
    write_reg(REG_IMMED_CYCLE, 16'($urandom_range(0, 3)));
    write_reg(REG_NM_CYCLE, 16'($urandom_range(0, 6)));
    write_reg(REG_NM_TIMEOUT, 16'($urandom_range(0, 20)));
    write_reg(REG_WAIT_BUS_SLP, 16'($urandom_range(0, 10)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: stay asleep, local and passive wake, reception held pending
  // through repeat message, back-to-back words on one channel.
  task automatic test_wake_paths();
    gap_pct   = 0;
    stall_pct = 0;
    send_tick(2'd2, 1'b0, 1'b0);
    send_tick(2'd0, 1'b1, 1'b0);
    send_tick(2'd1, 1'b0, 1'b1);
    send_tick(2'd3, 1'b1, 1'b1);
    send_tick(2'd3, 1'b1, 1'b0);
    send_tick(2'd0, 1'b1, 1'b1);
    send_tick(2'd0, 1'b1, 1'b0);
    send_tick(2'd0, 1'b0, 1'b0);
    send_tick(2'd1, 1'b0, 1'b0);
    idle_until_drained();
  endtask

  // All registers at their low end; the count is written with its top byte
  // set so only zero lands, and the burst wraps. Unmapped writes go nowhere.
  task automatic test_low_extremes();
    write_reg(REG_REPEAT_MSG, 16'h0000);
    write_reg(REG_IMMED_COUNT, 16'hFF00);
    write_reg(REG_IMMED_CYCLE, 16'h0000);
    write_reg(REG_NM_CYCLE, 16'h0000);
    write_reg(REG_NM_TIMEOUT, 16'h0000);
    write_reg(REG_WAIT_BUS_SLP, 16'h0000);
    write_reg(REG_UNMAPPED_6, 16'hFFFF);
    write_reg(REG_UNMAPPED_7, 16'h5A5A);
    send_tick(2'd2, 1'b0, 1'b1);   // passive wake
    send_tick(2'd2, 1'b1, 1'b0);   // zero dwell, on to normal
    send_tick(2'd2, 1'b1, 1'b1);   // normal drops the pending frame
    send_tick(2'd2, 1'b0, 1'b0);   // released: ready sleep
    send_tick(2'd2, 1'b0, 1'b1);   // reception holds ready sleep
    send_tick(2'd2, 1'b0, 1'b0);
    send_tick(2'd2, 1'b1, 1'b0);   // request again: normal from ready
    send_tick(2'd1, 1'b0, 1'b0);
    send_tick(2'd1, 1'b0, 1'b1);
    idle_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned words);
    load_random_config();
    gap_pct   = gap;
    stall_pct = stall;
    repeat (words) random_tick();
    idle_until_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipe fills and input stall has to rise.
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_req = ~hold_req;
    repeat (40) random_tick();
    idle_until_drained();
  endtask

  // All registers at their top end; run last since dwells this long never end.
  task automatic test_high_extremes();
    write_reg(REG_REPEAT_MSG, 16'hFFFF);
    write_reg(REG_IMMED_COUNT, 16'hFFFF);
    write_reg(REG_IMMED_CYCLE, 16'hFFFF);
    write_reg(REG_NM_CYCLE, 16'hFFFF);
    write_reg(REG_NM_TIMEOUT, 16'hFFFF);
    write_reg(REG_WAIT_BUS_SLP, 16'hFFFF);
    gap_pct   = 20;
    stall_pct = 20;
    repeat (12) random_tick();
    idle_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = PRESSURE_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Each accepted result word against the oldest expectation.
  nm_expect_t want_r;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results_q.size() == 0) begin
        $error("result word on channel %0d with no tick outstanding", out_channel_o);
        mismatch_count++;
      end else begin
        want_r = pending_results_q.pop_front();
        check_field("out_channel", want_r.channel, out_channel_o);
        check_field("new_state", want_r.res.new_state, new_state_o);
        check_field("send_nm", want_r.res.send_nm, send_nm_o);
        check_field("app_open", want_r.res.app_open, app_open_o);
        check_field("app_close", want_r.res.app_close, app_close_o);
        check_field("tx_state_code", want_r.res.tx_state_code, tx_state_code_o);
        check_field("wake_kind", want_r.res.wake_kind, wake_kind_o);
      end
    end
  end

  // Watchdog: too long with no handshake on either side means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("can_network_management_fsm: mismatch");
        $finish;
      end
    end
  end

  initial begin
    nm_cfg.repeat_msg_ticks      = RST_REPEAT_MSG;
    nm_cfg.immediate_count       = RST_IMMED_COUNT;
    nm_cfg.immediate_cycle_ticks = RST_IMMED_CYCLE;
    nm_cfg.nm_cycle_ticks        = RST_NM_CYCLE;
    nm_cfg.nm_timeout_ticks      = RST_NM_TIMEOUT;
    nm_cfg.wait_bus_sleep_ticks  = RST_WAIT_BUS_SLP;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      chan_ctx[ch]  = CTX_RST;
      req_level[ch] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_wake_paths();
    test_low_extremes();
    test_random_traffic(0, 0, 85);
    test_random_traffic(48, 0, 85);
    test_random_traffic(0, 48, 85);
    test_random_traffic(20, 20, 85);
    test_backpressure();
    test_high_extremes();

    if (mismatch_count == 0) begin
      $display("can_network_management_fsm: match");
    end else begin
      $display("can_network_management_fsm: mismatch");
    end
    $finish;
  end

endmodule

// ===== can_network_management_fsm.f =====
+incdir+rtl
rtl/cnm_pkg.sv
rtl/cnm_step.sv
rtl/can_network_management_fsm.sv
rtl/cnm_checker.sv
tb/can_network_management_fsm_tb.sv
